// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/lut3d_pkg.sv =====
`default_nettype none

package lut3d_pkg;

    localparam int MAX_CUBE_DEF   = 33;
    localparam int ENTRY_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [0:0] CFG_CUBE_SIZE    = 1'b0;
    localparam logic [0:0] CFG_BLEND_AMOUNT = 1'b1;

    localparam logic [5:0] CUBE_RESET  = 6'd33;
    localparam logic [5:0] CUBE_MIN    = 6'd2;
    localparam logic [8:0] BLEND_FULL  = 9'd256;

    // Request kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [2:0] LAST_CORNER = 3'd7;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SPLIT,
        F_ROW,
        F_PLANE,
        F_READ,
        F_DRAIN
    } lut3d_fetch_state_t;

    typedef enum logic [2:0] {
        D_IDLE,
        D_ESTIMATE,
        D_PRODUCT,
        D_CORRECT,
        D_BLEND
    } lut3d_fin_state_t;

endpackage

`default_nettype wire

// ===== hdl/lut3d_ram.sv =====
`default_nettype none

module lut3d_ram import lut3d_pkg::*; #(
    parameter int WIDTH = 3 * ENTRY_BITS_DEF,
    parameter int DEPTH = MAX_CUBE_DEF * MAX_CUBE_DEF * MAX_CUBE_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/lut3d_fetch.sv =====
`default_nettype none

// Splits the pixel into grid cells, reads the eight corners one per cycle and
// accumulates the weighted entries through a three-stage multiplier pipeline.
module lut3d_fetch import lut3d_pkg::*; #(
    parameter int MAX_CUBE   = MAX_CUBE_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         pixel_req,
    input  wire logic [2:0][7:0]                              pixel,
    input  wire logic [$clog2(MAX_CUBE+1)-1:0]                n,
    input  wire logic                                         fin_busy,
    output logic                                              busy,
    output logic [$clog2(MAX_CUBE*MAX_CUBE*MAX_CUBE)-1:0]     raddr,
    input  wire logic [3*ENTRY_BITS-1:0]                      rdata,
    output logic                                              go,
    output logic [2:0][ENTRY_BITS+23:0]                       acc,
    output logic [2:0][7:0]                                   pix
);

    localparam int NW    = $clog2(MAX_CUBE + 1);
    localparam int IW    = $clog2(MAX_CUBE);
    localparam int AW    = $clog2(MAX_CUBE * MAX_CUBE * MAX_CUBE);
    localparam int PW    = 8 + IW;
    localparam int PW1   = PW + 1;
    localparam int ACC_W = ENTRY_BITS + 24;

    lut3d_fetch_state_t state_reg, state_next;

    logic [2:0]       k_reg;
    logic             v1_reg, v2_reg, v3_reg;
    logic             pipe_empty;
    logic             issue;

    logic [2:0][7:0]  pix_reg;
    logic [IW-1:0]    lo_reg [3];
    logic [IW-1:0]    hi_reg [3];
    logic [7:0]       rem_reg [3];
    logic [IW-1:0]    lo_next [3];
    logic [IW-1:0]    hi_next [3];
    logic [7:0]       rem_next [3];
    logic [PW-1:0]    p [3];
    logic [PW1-1:0]   q1 [3];

    logic [AW-1:0]    rn_reg [2];
    logic [AW-1:0]    rg_reg [4];
    logic [AW-1:0]    rg_next [4];

    logic [7:0]       wr, wg, wb;
    logic [15:0]      wrg1_reg;
    logic [7:0]       wb1_reg;
    logic [23:0]      w2_reg;
    logic [3*ENTRY_BITS-1:0] e2_reg;
    logic [ACC_W-1:0] prod3_reg [3];
    logic [2:0][ACC_W-1:0] acc_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (pixel_req) state_next = F_SPLIT;
            F_SPLIT: state_next = F_ROW;
            F_ROW:   state_next = F_PLANE;
            F_PLANE: state_next = F_READ;
            F_READ:  if (k_reg == LAST_CORNER) state_next = F_DRAIN;
            F_DRAIN: if (pipe_empty && !fin_busy) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        busy  = (state_reg != F_IDLE);
        issue = (state_reg == F_READ);
        go    = (state_reg == F_DRAIN) && pipe_empty && !fin_busy;
    end

    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            k_reg     <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= issue ? k_reg + 3'd1 : '0;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    // Lower grid index and remainder: p / 255 as (p + p/256 + 1) / 256, and the
    // remainder p - 255*q taken modulo 256, where it always lies.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            p[ch]        = PW'(pix_reg[ch]) * PW'(n - NW'(1));
            q1[ch]       = (PW1'(p[ch]) + PW1'(p[ch] >> 8) + PW1'(1)) >> 8;
            lo_next[ch]  = IW'(q1[ch]);
            rem_next[ch] = p[ch][7:0] + q1[ch][7:0];
            hi_next[ch]  = (rem_next[ch] != 8'd0) ? lo_next[ch] + IW'(1) : lo_next[ch];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            rg_next[j] = AW'((rn_reg[j >> 1]
                         + AW'(((j & 1) != 0) ? hi_reg[1] : lo_reg[1])) * AW'(n));
        end
    end

    assign raddr = rg_reg[k_reg[2:1]] + AW'(k_reg[0] ? hi_reg[2] : lo_reg[2]);

    // Corner weights; 255 - rem is the bitwise inverse of an 8-bit value.
    assign wr = k_reg[2] ? rem_reg[0] : ~rem_reg[0];
    assign wg = k_reg[1] ? rem_reg[1] : ~rem_reg[1];
    assign wb = k_reg[0] ? rem_reg[2] : ~rem_reg[2];

    always_ff @(posedge clk)
    begin
        if (pixel_req)
        begin
            pix_reg <= pixel;
        end
        if (state_reg == F_SPLIT)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                lo_reg[ch]  <= lo_next[ch];
                hi_reg[ch]  <= hi_next[ch];
                rem_reg[ch] <= rem_next[ch];
            end
        end
        if (state_reg == F_ROW)
        begin
            rn_reg[0] <= AW'(AW'(lo_reg[0]) * AW'(n));
            rn_reg[1] <= AW'(AW'(hi_reg[0]) * AW'(n));
        end
        if (state_reg == F_PLANE)
        begin
            for (int j = 0; j < 4; j++)
            begin
                rg_reg[j] <= rg_next[j];
            end
        end
        wrg1_reg <= 16'(wr) * 16'(wg);
        wb1_reg  <= wb;
        w2_reg   <= 24'(wrg1_reg) * 24'(wb1_reg);
        e2_reg   <= rdata;
        for (int ch = 0; ch < 3; ch++)
        begin
            prod3_reg[ch] <= ACC_W'(e2_reg[ch*ENTRY_BITS +: ENTRY_BITS]) * ACC_W'(w2_reg);
            if (pixel_req)
            begin
                acc_reg[ch] <= '0;
            end
            else if (v3_reg)
            begin
                acc_reg[ch] <= acc_reg[ch] + prod3_reg[ch];
            end
        end
    end

    assign acc = acc_reg;
    assign pix = pix_reg;

endmodule

`default_nettype wire

// ===== hdl/lut3d_finish.sv =====
`default_nettype none

// Scales the accumulated sums to 8 bits with rounding, then blends. The
// quotient is first estimated from the top bits of the dividend with a
// reciprocal multiplication; the estimate is never high and at most one low,
// so one compare of the remainder against the divisor finishes it.
module lut3d_finish import lut3d_pkg::*; #(
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       go,
    input  wire logic [2:0][ENTRY_BITS+23:0] acc,
    input  wire logic [2:0][7:0]            pix,
    input  wire logic [8:0]                 blend,
    output logic                            busy,
    output logic                            done,
    output logic [2:0][7:0]                 result
);

    localparam int DW    = ENTRY_BITS + 25;
    // Low dividend bits left out of the estimate; they add less than a
    // hundredth of a quotient step.
    localparam int SHIFT = ENTRY_BITS + 10;
    localparam longint unsigned DEN   = 64'd65025 * ((64'd1 << ENTRY_BITS) - 64'd1);
    localparam longint unsigned DEN2  = DEN << 1;
    localparam longint unsigned RECIP = (64'd1 << (SHIFT + 16)) / DEN2;
    localparam logic [DW-1:0] DEN_W   = DW'(DEN);
    localparam logic [DW-1:0] DEN2_W  = DW'(DEN2);
    localparam logic [23:0]   RECIP_W = 24'(RECIP);

    lut3d_fin_state_t state_reg, state_next;

    logic             done_reg;
    logic             load, est_en, prod_en, fix_en, blend_en;
    logic [DW-1:0]    x_reg [3];
    logic [7:0]       qe_reg [3];
    logic [DW-1:0]    prod_reg [3];
    logic [7:0]       q_reg [3];
    logic [23:0]      est [3];
    logic [DW-1:0]    rem_w [3];
    logic [2:0][7:0]  pix_reg;
    logic [2:0][7:0]  out_reg;
    logic [16:0]      mix [3];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:     if (go) state_next = D_ESTIMATE;
            D_ESTIMATE: state_next = D_PRODUCT;
            D_PRODUCT:  state_next = D_CORRECT;
            D_CORRECT:  state_next = D_BLEND;
            D_BLEND:    state_next = D_IDLE;
            default:    state_next = D_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = (state_reg != D_IDLE);
        load     = (state_reg == D_IDLE) && go;
        est_en   = (state_reg == D_ESTIMATE);
        prod_en  = (state_reg == D_PRODUCT);
        fix_en   = (state_reg == D_CORRECT);
        blend_en = (state_reg == D_BLEND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= blend_en;
        end
    end

    // The sum never exceeds 255 times the full-scale weight, so the quotient
    // fits in eight bits and no saturation is needed.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            est[ch]   = 24'(x_reg[ch][DW-1:SHIFT]) * RECIP_W;
            rem_w[ch] = x_reg[ch] - prod_reg[ch];
            mix[ch]   = 17'(pix_reg[ch]) * 17'(BLEND_FULL - blend)
                      + 17'(q_reg[ch]) * 17'(blend);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg <= pix;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (load)
            begin
                x_reg[ch] <= {acc[ch], 1'b0} + DEN_W;
            end
            if (est_en)
            begin
                qe_reg[ch] <= est[ch][23:16];
            end
            if (prod_en)
            begin
                prod_reg[ch] <= DW'(qe_reg[ch]) * DEN2_W;
            end
            if (fix_en)
            begin
                q_reg[ch] <= qe_reg[ch] + ((rem_w[ch] >= DEN2_W) ? 8'd1 : 8'd0);
            end
            if (blend_en)
            begin
                out_reg[ch] <= mix[ch][15:8];
            end
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

// ===== hdl/lut3d_trilinear_color_grade.sv =====
`default_nettype none

// Channel   Ports                                   Handshake
// request   kind, entry_*, pixel_*                  start high while busy low
// result    out_red, out_green, out_blue            done high for one cycle
// config    cfg_index, cfg_data                     cfg_valid and cfg_ready
//
// A load request is taken and leaves busy low. A pixel request holds busy
// through the split, row and plane address setup states, the eight corner
// reads through the single table read port and the multiplier pipeline drain
// after them; the drain also waits while the scaling back end is busy. A new
// pixel is accepted only once the front end is through with the last one, and
// the scaling and blend of that one overlap the next pixel's address setup. The
// receiver cannot stall results. Reset clears control and configuration only;
// the table holds whatever was last written and must be loaded before use.

`include "assert_macros.svh"

module lut3d_trilinear_color_grade import lut3d_pkg::*; #(
    parameter int MAX_CUBE   = MAX_CUBE_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [15:0] entry_index,
    input  wire logic [15:0] entry_red,
    input  wire logic [15:0] entry_green,
    input  wire logic [15:0] entry_blue,
    input  wire logic [7:0]  pixel_red,
    input  wire logic [7:0]  pixel_green,
    input  wire logic [7:0]  pixel_blue,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    output logic             done,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue
);

    localparam int DEPTH = MAX_CUBE * MAX_CUBE * MAX_CUBE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_CUBE + 1);
    localparam int ACC_W = ENTRY_BITS + 24;

    logic [5:0]             cube_size_reg;
    logic [8:0]             blend_amount_reg;
    logic [NW-1:0]          n_eff;
    logic [8:0]             blend_eff;

    logic                   accept;
    logic                   load_we;
    logic                   pixel_req;
    logic                   fin_busy;
    logic                   go;
    logic [AW-1:0]          raddr;
    logic [3*ENTRY_BITS-1:0] rdata;
    logic [3*ENTRY_BITS-1:0] wdata;
    logic [2:0][ACC_W-1:0]  acc;
    logic [2:0][7:0]        pix;
    logic [2:0][7:0]        pixel_bus;
    logic [2:0][7:0]        result;

    // Configuration registers are to be written only while the block is idle (the
    // block itself does not enforce this), and the port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_size_reg    <= CUBE_RESET;
            blend_amount_reg <= BLEND_FULL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CUBE_SIZE:    cube_size_reg    <= cfg_data[5:0];
                CFG_BLEND_AMOUNT: blend_amount_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Out-of-range settings are clamped: the grid to 2..MAX_CUBE points, the
    // opacity to full.
    always_comb
    begin
        if (cube_size_reg < CUBE_MIN)
        begin
            n_eff = NW'(2);
        end
        else if (32'(cube_size_reg) > MAX_CUBE)
        begin
            n_eff = NW'(MAX_CUBE);
        end
        else
        begin
            n_eff = NW'(cube_size_reg);
        end
        blend_eff = (blend_amount_reg > BLEND_FULL) ? BLEND_FULL : blend_amount_reg;
    end

    // A load writes the table straight from the request ports; an index past
    // the end of the table is dropped. Only the low ENTRY_BITS of each value
    // are kept.
    assign accept    = start && !busy;
    assign load_we   = accept && (kind == KIND_LOAD) && (32'(entry_index) < DEPTH);
    assign pixel_req = accept && (kind == KIND_PIXEL);
    assign wdata     = {entry_blue[ENTRY_BITS-1:0], entry_green[ENTRY_BITS-1:0],
                        entry_red[ENTRY_BITS-1:0]};
    assign pixel_bus = {pixel_blue, pixel_green, pixel_red};

    lut3d_ram #(
        .WIDTH (3 * ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(entry_index)),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Front end: grid split, corner addressing and weighted accumulation.
    lut3d_fetch #(
        .MAX_CUBE   (MAX_CUBE),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_req (pixel_req),
        .pixel     (pixel_bus),
        .n         (n_eff),
        .fin_busy  (fin_busy),
        .busy      (busy),
        .raddr     (raddr),
        .rdata     (rdata),
        .go        (go),
        .acc       (acc),
        .pix       (pix)
    );

    // Back end: rounding scale and opacity blend, overlapping the next pixel.
    lut3d_finish #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_finish (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .acc    (acc),
        .pix    (pix),
        .blend  (blend_eff),
        .busy   (fin_busy),
        .done   (done),
        .result (result)
    );

    assign out_red   = result[0];
    assign out_green = result[1];
    assign out_blue  = result[2];

    // A result strobe lasts exactly one cycle and always closes a scaling pass.
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result strobe longer than one cycle")
    `ASSERT_IMPLY(a_done_from_div, clk, rst_n, done, $past(fin_busy), "result without scaling")
    // A pixel request starts the sequencer; a load request never does.
    `ASSERT_NEXT(a_pixel_busy, clk, rst_n, pixel_req, busy, "pixel request did not raise busy")
    `ASSERT_NEXT(a_load_idle, clk, rst_n, start && !busy && (kind == KIND_LOAD), !busy,
        "load request raised busy")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import lut3d_pkg::*;

    // The table spans the full cube, so every size that the block can be set to
    // addresses only entries inside it.
    localparam int TABLE_DEPTH = MAX_CUBE_DEF * MAX_CUBE_DEF * MAX_CUBE_DEF;
    localparam logic [15:0] ENTRY_FULL = 16'((1 << ENTRY_BITS_DEF) - 1);

    // This margin covers the time from a pixel request to its result before the
    // bench touches the registers or ends the run.
    localparam int DRAIN_CYCLES   = 40;
    localparam int SETTLE_LIMIT   = 4000;
    localparam int ITEMS_PER_STEP = 66;
    localparam int FIXED_SETTINGS = 7;
    localparam int RANDOM_SETTINGS = 2;
    localparam int REPORT_LIMIT   = 10;

    // Register settings visited after the reset values. They cover the smallest
    // and largest cubes, a cube size below the minimum, sizes above the maximum,
    // upper data bits that the cube register drops, and opacities of none, partial
    // and above full.
    localparam logic [8:0] CUBE_SETTINGS [FIXED_SETTINGS] =
        '{9'd2, 9'd0, 9'd63, 9'd18, 9'd16, 9'h1E1, 9'd34};
    localparam logic [8:0] BLEND_SETTINGS [FIXED_SETTINGS] =
        '{9'd0, 9'd128, 9'd511, 9'd257, 9'd1, 9'd255, 9'd200};

    typedef struct packed {
        logic        kind;
        logic [15:0] index;
        logic [15:0] ered;
        logic [15:0] egreen;
        logic [15:0] eblue;
        logic [7:0]  pred;
        logic [7:0]  pgreen;
        logic [7:0]  pblue;
    } grade_request_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } graded_pixel_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } table_entry_t;

    // The scoreboard keeps its own copy of the color table and of both
    // registers. Every accepted request goes through note_request: a load
    // updates the table copy, a pixel is graded at once and its expected
    // output waits in order for the block's result.
    class GradeScoreboard;
        table_entry_t  lut [TABLE_DEPTH];
        bit            written [TABLE_DEPTH];
        logic [5:0]    cube_reg;
        logic [8:0]    blend_reg;
        graded_pixel_t expected_pixels [$];
        int            faults;
        int            checked;

        function new();
            cube_reg  = CUBE_RESET;
            blend_reg = BLEND_FULL;
            faults    = 0;
            checked   = 0;
        endfunction

        function void write_register(logic [0:0] idx, logic [8:0] data);
            if (idx == CFG_CUBE_SIZE)
                cube_reg = data[5:0];
            else
                blend_reg = data;
        endfunction

        // Grid points per axis actually in use, after clamping.
        function int unsigned grid_points();
            int unsigned n;
            n = cube_reg;
            if (n < CUBE_MIN)
                n = CUBE_MIN;
            if (n > MAX_CUBE_DEF)
                n = MAX_CUBE_DEF;
            return n;
        endfunction

        // Flat table position of corner k of the cell that holds a pixel; bit 2
        // of k picks the upper red index, bit 1 the green and bit 0 the blue.
        function int unsigned corner_index(grade_request_t req, int k);
            int unsigned n, p, lo, rem;
            int unsigned chv [3], pos [3];
            n = grid_points();
            chv[0] = req.pred;
            chv[1] = req.pgreen;
            chv[2] = req.pblue;
            for (int ch = 0; ch < 3; ch++)
            begin
                p   = chv[ch] * (n - 1);
                lo  = p / 255;
                rem = p % 255;
                pos[ch] = ((((k >> (2 - ch)) & 1) != 0) && (rem != 0)) ? lo + 1 : lo;
            end
            return (pos[0] * n + pos[1]) * n + pos[2];
        endfunction

        function void note_request(grade_request_t req);
            int unsigned   n, a, p, ri, gi, bi, flat;
            int unsigned   lo [3], hi [3], rem [3], pix [3];
            longint unsigned acc, den, graded, mixed, weight, comp;
            table_entry_t  e;
            logic [7:0]    outc [3];
            if (req.kind == KIND_LOAD)
            begin
                // An index past the end of the table is dropped by the block.
                if (req.index < TABLE_DEPTH)
                begin
                    lut[req.index] = '{req.ered, req.egreen, req.eblue};
                    written[req.index] = 1'b1;
                end
                return;
            end
            n = grid_points();
            a = (blend_reg > BLEND_FULL) ? BLEND_FULL : blend_reg;
            pix[0] = req.pred;
            pix[1] = req.pgreen;
            pix[2] = req.pblue;
            // Split each channel's grid position exactly into a lower index
            // and a remainder in 255ths. On an exact grid point the upper
            // corner collapses onto the lower one.
            for (int ch = 0; ch < 3; ch++)
            begin
                p       = pix[ch] * (n - 1);
                lo[ch]  = p / 255;
                rem[ch] = p % 255;
                hi[ch]  = (rem[ch] != 0) ? lo[ch] + 1 : lo[ch];
            end
            den = 64'd255 * 64'd255 * 64'(ENTRY_FULL);
            for (int ch = 0; ch < 3; ch++)
            begin
                acc = 0;
                for (int k = 0; k < 8; k++)
                begin
                    ri = ((k & 4) != 0) ? hi[0] : lo[0];
                    gi = ((k & 2) != 0) ? hi[1] : lo[1];
                    bi = ((k & 1) != 0) ? hi[2] : lo[2];
                    weight = (((k & 4) != 0) ? rem[0] : 255 - rem[0]);
                    weight = weight * (((k & 2) != 0) ? rem[1] : 255 - rem[1]);
                    weight = weight * (((k & 1) != 0) ? rem[2] : 255 - rem[2]);
                    flat = (ri * n + gi) * n + bi;
                    e = lut[flat];
                    comp = (ch == 0) ? e.red : ((ch == 1) ? e.green : e.blue);
                    acc = acc + comp * weight;
                end
                // Scale to 8 bits, round half up, saturate, then mix with the
                // original channel by opacity and truncate.
                graded = (2 * acc + den) / (2 * den);
                if (graded > 255)
                    graded = 255;
                mixed = (longint'(pix[ch]) * (256 - a) + graded * a) >> 8;
                outc[ch] = mixed[7:0];
            end
            expected_pixels.push_back(graded_pixel_t'{outc[0], outc[1], outc[2]});
        endfunction

        function void check_result(graded_pixel_t got);
            graded_pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("unexpected graded pixel %0d/%0d/%0d",
                             got.red, got.green, got.blue);
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("graded pixel %0d differs: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             checked, want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function void close_out();
            if (expected_pixels.size() != 0)
            begin
                faults += expected_pixels.size();
                $display("%0d graded pixels never came out", expected_pixels.size());
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [15:0] entry_index;
    logic [15:0] entry_red;
    logic [15:0] entry_green;
    logic [15:0] entry_blue;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        done;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;

    GradeScoreboard sb;
    int loads_sent;
    int pixels_sent;
    int settings_run;
    int burst_left;

    lut3d_trilinear_color_grade u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .entry_index (entry_index),
        .entry_red   (entry_red),
        .entry_green (entry_green),
        .entry_blue  (entry_blue),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The receiver cannot stall the block, so every strobed cycle is a result.
    // Sampling in the active region of the rising edge sees the values that
    // the block held during the cycle that ends there.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{out_red, out_green, out_blue});
    end

    // Loads and pixels share one request channel. Fields change at the falling
    // edge; the request is taken at the first rising edge with busy low. Without a
    // gap the task returns at the falling edge after that, with start still high,
    // so back-to-back requests never drop start between them.
    task automatic send_request(grade_request_t req, bit with_gap);
        int gap;
        kind        = req.kind;
        entry_index = req.index;
        entry_red   = req.ered;
        entry_green = req.egreen;
        entry_blue  = req.eblue;
        pixel_red   = req.pred;
        pixel_green = req.pgreen;
        pixel_blue  = req.pblue;
        start       = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(req);
        if (req.kind == KIND_PIXEL)
            pixels_sent++;
        else
            loads_sent++;
        @(negedge clk);
        if (with_gap)
        begin
            // Random idle cycles, broken now and then by a run of requests
            // sent with no idling at all.
            gap = 0;
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    burst_left = $urandom_range(10, 30);
                gap = $urandom_range(0, 8);
            end
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic write_register(logic [0:0] idx, logic [8:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Lets every outstanding pixel come out, then waits out the pipeline so
    // that the block is truly idle. A result that never comes is caught at
    // the end as a leftover expectation.
    task automatic settle();
        int guard;
        start = 1'b0;
        guard = 0;
        while (sb.expected_pixels.size() != 0 && guard < SETTLE_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic grade_request_t make_load(int idx, logic [15:0] r,
                                                 logic [15:0] g, logic [15:0] b);
        grade_request_t req;
        req        = '0;
        req.kind   = KIND_LOAD;
        req.index  = 16'(idx);
        req.ered   = r;
        req.egreen = g;
        req.eblue  = b;
        req.pred   = 8'($urandom);
        req.pgreen = 8'($urandom);
        req.pblue  = 8'($urandom);
        return req;
    endfunction

    function automatic grade_request_t make_pixel(logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b);
        grade_request_t req;
        req        = '0;
        req.kind   = KIND_PIXEL;
        req.index  = 16'($urandom);
        req.ered   = 16'($urandom);
        req.egreen = 16'($urandom);
        req.eblue  = 16'($urandom);
        req.pred   = r;
        req.pgreen = g;
        req.pblue  = b;
        return req;
    endfunction

    function automatic logic [15:0] pick_entry_value();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return ENTRY_FULL;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Channel values lean toward the ends and toward exact grid points of the
    // 16- and 18-point cubes, where the upper corner equals the lower one.
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'(15 * $urandom_range(0, 17));
            3: return 8'(17 * $urandom_range(0, 15));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Reset leaves the table undefined, so a pixel goes in only once every
    // corner that it reads has been loaded; missing corners are loaded first
    // with random values.
    task automatic send_pixel(grade_request_t req, bit with_gap);
        int unsigned idx;
        for (int k = 0; k < 8; k++)
        begin
            idx = sb.corner_index(req, k);
            if (!sb.written[idx])
                send_request(make_load(int'(idx), pick_entry_value(), pick_entry_value(),
                                       pick_entry_value()), with_gap);
        end
        send_request(req, with_gap);
    endtask

    // A mix of pixels and table loads, counting every request sent. Most
    // random loads land inside the cube in use so they change what later
    // pixels read; some go elsewhere in the table, and a few fall past its
    // end and must be dropped.
    task automatic random_requests(int count);
        grade_request_t req;
        int n;
        int idx;
        int stop;
        stop = loads_sent + pixels_sent + count;
        while (loads_sent + pixels_sent < stop)
        begin
            if ($urandom_range(0, 99) < 25)
            begin
                n = sb.grid_points();
                case ($urandom_range(0, 9))
                    0: idx = $urandom_range(TABLE_DEPTH, 65535);
                    1, 2: idx = $urandom_range(0, TABLE_DEPTH - 1);
                    default: idx = $urandom_range(0, n * n * n - 1);
                endcase
                req = make_load(idx, pick_entry_value(), pick_entry_value(),
                                pick_entry_value());
                send_request(req, 1'b1);
            end
            else
            begin
                send_pixel(make_pixel(pick_channel(), pick_channel(), pick_channel()), 1'b1);
            end
        end
    endtask

    // Short directed checks under the reset settings: the table corners at
    // their extremes, the ends of every channel, loads past the table end both
    // just beyond it and with all index bits set, and a mid-scale entry value.
    task automatic directed_requests();
        send_request(make_load(0, ENTRY_FULL, ENTRY_FULL, ENTRY_FULL), 1'b0);
        send_request(make_load(TABLE_DEPTH - 1, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0), 1'b1);
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255), 1'b1);
        send_request(make_load(16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC), 1'b0);
        send_request(make_load(TABLE_DEPTH, 16'hAAAA, 16'h5555, 16'hFFFF), 1'b1);
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0), 1'b1);
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255), 1'b1);
        send_pixel(make_pixel(8'd0, 8'd255, 8'd128), 1'b1);
        send_pixel(make_pixel(8'd255, 8'd0, 8'd1), 1'b1);
        send_pixel(make_pixel(8'd1, 8'd254, 8'd127), 1'b1);
        send_pixel(make_pixel(8'd128, 8'd128, 8'd128), 1'b0);
        send_request(make_load(0, 16'h8000, 16'h7FFF, 16'h0001), 1'b0);
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0), 1'b1);
        send_pixel(make_pixel(8'd3, 8'd2, 8'd1), 1'b1);
        send_request(make_load(TABLE_DEPTH - 1, 16'hFFFE, 16'h0100, 16'hFFFF), 1'b0);
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255), 1'b1);
        send_pixel(make_pixel(8'd254, 8'd253, 8'd252), 1'b1);
    endtask

    initial
    begin
        sb          = new();
        loads_sent  = 0;
        pixels_sent = 0;
        settings_run = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_LOAD;
        entry_index = '0;
        entry_red   = '0;
        entry_green = '0;
        entry_blue  = '0;
        pixel_red   = '0;
        pixel_green = '0;
        pixel_blue  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_CUBE_SIZE;
        cfg_data    = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_requests();
        random_requests(ITEMS_PER_STEP);
        settings_run = 1;

        // Registers change only with the block idle and every result in.
        for (int s = 0; s < FIXED_SETTINGS + RANDOM_SETTINGS; s++)
        begin
            settle();
            if (s < FIXED_SETTINGS)
            begin
                write_register(CFG_CUBE_SIZE, CUBE_SETTINGS[s]);
                write_register(CFG_BLEND_AMOUNT, BLEND_SETTINGS[s]);
            end
            else
            begin
                write_register(CFG_BLEND_AMOUNT, 9'($urandom_range(0, 511)));
                write_register(CFG_CUBE_SIZE, 9'($urandom_range(0, 511)));
            end
            // The ends of every channel are exact grid points in any cube.
            send_pixel(make_pixel(8'd0, 8'd255, 8'd0), 1'b1);
            send_pixel(make_pixel(8'd255, 8'd0, 8'd255), 1'b1);
            random_requests(ITEMS_PER_STEP);
            settings_run++;
        end

        settle();
        sb.close_out();
        $display("Ran %0d table loads and %0d pixels over %0d register settings.",
                 loads_sent, pixels_sent, settings_run);
        $display("Checked %0d graded pixels against the predicted values.", sb.checked);
        if (sb.faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: many times the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== lut3d_trilinear_color_grade.f =====
+incdir+hdl
hdl/lut3d_pkg.sv
hdl/lut3d_ram.sv
hdl/lut3d_fetch.sv
hdl/lut3d_finish.sv
hdl/lut3d_trilinear_color_grade.sv
bench/testbench.sv
